// ----- rtl/astc_pkg.sv -----
// Package: scan modes, style classes and character-class and keyword functions.
`default_nettype none
package astc_pkg;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_COMMENT = 3'd1,
    M_STRING  = 3'd2,
    M_ESCAPE  = 3'd3,
    M_NUMBER  = 3'd4,
    M_LABEL   = 3'd5,
    M_OPCODE  = 3'd6,
    M_OPERAND = 3'd7
  } scan_mode_t;

  typedef enum logic [2:0] {
    C_DEFAULT   = 3'd0,
    C_COMMENT   = 3'd1,
    C_STRING    = 3'd2,
    C_MNEMONIC  = 3'd3,
    C_DIRECTIVE = 3'd4,
    C_REGISTER  = 3'd5,
    C_NUMBER    = 3'd6,
    C_LABEL     = 3'd7
  } style_t;

  // Keyword buffer for matching: eight lowered characters, zero padded.
  localparam int KW_LEN = 8;
  typedef logic [KW_LEN*8-1:0] kw_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'hAA || c == 8'hB5 || c == 8'hBA ||
           (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
  endfunction

  function automatic logic is_number(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || c == 8'hB2 || c == 8'hB3 || c == 8'hB9 ||
           (c >= 8'hBC && c <= 8'hBE);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_letter(c) || is_number(c) || c == CH_UNDER || c == CH_DOT ||
           c == CH_AT || c == CH_DOLLAR;
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // Pack a keyword string, first character in the low byte.
  function automatic kw_t kw(input string s);
    kw_t r;
    r = '0;
    for (int i = 0; i < s.len() && i < KW_LEN; i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic logic is_mnem(input kw_t w);
    logic h;
    h = 1'b0;
    h |= w == kw("move") || w == kw("movea") || w == kw("movem") || w == kw("movep");
    h |= w == kw("moveq") || w == kw("lea") || w == kw("pea") || w == kw("link");
    h |= w == kw("unlk") || w == kw("exg") || w == kw("swap") || w == kw("clr");
    h |= w == kw("ext") || w == kw("extb") || w == kw("add") || w == kw("adda");
    h |= w == kw("addi") || w == kw("addq") || w == kw("addx") || w == kw("sub");
    h |= w == kw("suba") || w == kw("subi") || w == kw("subq") || w == kw("subx");
    h |= w == kw("neg") || w == kw("negx") || w == kw("cmp") || w == kw("cmpa");
    h |= w == kw("cmpi") || w == kw("cmpm") || w == kw("muls") || w == kw("mulu");
    h |= w == kw("divs") || w == kw("divu") || w == kw("abcd") || w == kw("sbcd");
    h |= w == kw("nbcd") || w == kw("and") || w == kw("andi") || w == kw("or");
    h |= w == kw("ori") || w == kw("eor") || w == kw("eori") || w == kw("not");
    h |= w == kw("asl") || w == kw("asr") || w == kw("lsl") || w == kw("lsr");
    h |= w == kw("rol") || w == kw("ror") || w == kw("roxl") || w == kw("roxr");
    h |= w == kw("btst") || w == kw("bset") || w == kw("bclr") || w == kw("bchg");
    h |= w == kw("bra") || w == kw("bsr") || w == kw("beq") || w == kw("bne");
    h |= w == kw("bcc") || w == kw("bcs") || w == kw("bhi") || w == kw("bls");
    h |= w == kw("bge") || w == kw("blt") || w == kw("bgt") || w == kw("ble");
    h |= w == kw("bpl") || w == kw("bmi") || w == kw("bvc") || w == kw("bvs");
    h |= w == kw("bhs") || w == kw("blo") || w == kw("dbra") || w == kw("dbf");
    h |= w == kw("dbt") || w == kw("dbeq") || w == kw("dbne") || w == kw("dbcc");
    h |= w == kw("dbcs") || w == kw("dbhi") || w == kw("dbls") || w == kw("dbge");
    h |= w == kw("dblt") || w == kw("dbgt") || w == kw("dble") || w == kw("dbpl");
    h |= w == kw("dbmi") || w == kw("dbvc") || w == kw("dbvs") || w == kw("seq");
    h |= w == kw("sne") || w == kw("scc") || w == kw("scs") || w == kw("shi");
    h |= w == kw("sls") || w == kw("sge") || w == kw("slt") || w == kw("sgt");
    h |= w == kw("sle") || w == kw("spl") || w == kw("smi") || w == kw("svc");
    h |= w == kw("svs") || w == kw("st") || w == kw("sf") || w == kw("jmp");
    h |= w == kw("jsr") || w == kw("rts") || w == kw("rte") || w == kw("rtr");
    h |= w == kw("trap") || w == kw("trapv") || w == kw("chk") || w == kw("tas");
    h |= w == kw("nop") || w == kw("reset") || w == kw("stop") || w == kw("illegal");
    return h;
  endfunction

  function automatic logic is_dir(input kw_t w);
    logic h;
    h = 1'b0;
    h |= w == kw("dc") || w == kw("ds") || w == kw("dcb") || w == kw("equ");
    h |= w == kw("org") || w == kw("section") || w == kw("even") || w == kw("odd");
    h |= w == kw("cnop") || w == kw("include") || w == kw("incbin") || w == kw("incdir");
    h |= w == kw("macro") || w == kw("endm") || w == kw("mexit") || w == kw("rept");
    h |= w == kw("endr") || w == kw("if") || w == kw("ifeq") || w == kw("ifne");
    h |= w == kw("ifgt") || w == kw("iflt") || w == kw("ifd") || w == kw("ifnd");
    h |= w == kw("else") || w == kw("endif") || w == kw("public") || w == kw("xdef");
    h |= w == kw("xref") || w == kw("extern") || w == kw("global") || w == kw("list");
    h |= w == kw("nolist") || w == kw("module") || w == kw("end") || w == kw("fail");
    h |= w == kw("opt");
    return h;
  endfunction

  function automatic logic is_reg(input kw_t w);
    logic h;
    h = 1'b0;
    h |= w == kw("d0") || w == kw("d1") || w == kw("d2") || w == kw("d3");
    h |= w == kw("d4") || w == kw("d5") || w == kw("d6") || w == kw("d7");
    h |= w == kw("a0") || w == kw("a1") || w == kw("a2") || w == kw("a3");
    h |= w == kw("a4") || w == kw("a5") || w == kw("a6") || w == kw("a7");
    h |= w == kw("sp") || w == kw("usp") || w == kw("ssp") || w == kw("pc");
    h |= w == kw("sr") || w == kw("ccr");
    return h;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/asm_source_token_classifier.sv -----
// Top level: 68000 assembler source tokenizer emitting style runs.
// Latency: the first run of a character is offered the cycle after acceptance.
// Throughput: one character per cycle while out_stall is low; a character with two
// runs holds the input while its first run is offered.
// Reset: synchronous active-low rst_n; idle, column zero, no open run.
`default_nettype none
module asm_source_token_classifier import astc_pkg::*; #(
  parameter int MAX_WORD = 10,
  parameter int RUN_MAX  = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_chunk_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_run_length,
  output logic [2:0]       out_style_class,
  output logic             out_run_last
);
  localparam int LW = $clog2(MAX_WORD + 2);
  localparam int RW = $clog2(RUN_MAX + 1);

  scan_mode_t mode_r, mode_nxt, step_mode;
  logic col0_r, col0_nxt, step_col0, mseen_r, mseen_nxt, step_mseen;
  logic [RW-1:0] cnt_r, cnt_nxt, step_cnt;
  logic [MAX_WORD*8-1:0] wbuf_r, wbuf_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt, dot_r, dot_nxt;
  logic [7:0] quote_r, quote_nxt;
  logic push, start;

  // Result slots: up to two runs per character.
  logic [1:0] nres, tot_res, pend_r, pend_nxt;
  logic [15:0] len0, len1, f_len0, f_len1, len0_r, len1_r;
  style_t cls0, cls1, f_cls0, f_cls1, cls0_r, cls1_r;

  style_t wstyle, oclass, tail_wstyle, tail_cls;
  logic accept;

  astc_word_class #(.MAX_WORD(MAX_WORD)) u_wc (
    .word_chars(wbuf_r), .word_len(wlen_r), .last_dot_pos(dot_r),
    .operand(mode_r == M_OPERAND), .word_style(wstyle)
  );

  always_comb begin
    unique case (mode_r)
      M_COMMENT:          oclass = C_COMMENT;
      M_STRING, M_ESCAPE: oclass = C_STRING;
      M_NUMBER:           oclass = C_NUMBER;
      M_LABEL:            oclass = C_LABEL;
      M_OPCODE, M_OPERAND: oclass = wstyle;
      default:            oclass = C_DEFAULT;
    endcase
  end

  assign in_stall = (pend_r == 2'd2) || (pend_r == 2'd1 && out_stall);
  assign accept = in_valid && !in_stall;

  astc_step #(.RUN_MAX(RUN_MAX)) u_step (
    .c(in_char_code), .mode(mode_r), .col0(col0_r), .mseen(mseen_r), .cnt(cnt_r),
    .quote(quote_r), .oclass(oclass),
    .mode_o(step_mode), .cnt_o(step_cnt), .col0_o(step_col0), .mseen_o(step_mseen),
    .quote_o(quote_nxt), .push_o(push), .start_o(start), .nres_o(nres),
    .len0_o(len0), .len1_o(len1), .cls0_o(cls0), .cls1_o(cls1)
  );

  always_comb begin
    wbuf_nxt = wbuf_r; wlen_nxt = wlen_r; dot_nxt = dot_r;
    if (start) begin
      wbuf_nxt[7:0] = in_char_code;
      wlen_nxt = LW'(1);
      dot_nxt = (in_char_code == CH_DOT) ? LW'(1) : LW'(0);
    end else if (push) begin
      if (wlen_r < LW'(MAX_WORD)) begin
        for (int i = 0; i < MAX_WORD; i++)
          if (LW'(i) == wlen_r) wbuf_nxt[i*8 +: 8] = in_char_code;
        if (in_char_code == CH_DOT) dot_nxt = wlen_r + LW'(1);
        wlen_nxt = wlen_r + LW'(1);
      end else wlen_nxt = LW'(MAX_WORD + 1);
    end
  end

  // Class of a run still open at chunk end, taken from the post-step state.
  astc_word_class #(.MAX_WORD(MAX_WORD)) u_wc_tail (
    .word_chars(wbuf_nxt), .word_len(wlen_nxt), .last_dot_pos(dot_nxt),
    .operand(step_mode == M_OPERAND), .word_style(tail_wstyle)
  );

  always_comb begin
    unique case (step_mode)
      M_COMMENT:           tail_cls = C_COMMENT;
      M_STRING, M_ESCAPE:  tail_cls = C_STRING;
      M_NUMBER:            tail_cls = C_NUMBER;
      M_LABEL:             tail_cls = C_LABEL;
      M_OPCODE, M_OPERAND: tail_cls = tail_wstyle;
      default:             tail_cls = C_DEFAULT;
    endcase
  end

  always_comb begin
    mode_nxt = step_mode; col0_nxt = step_col0; mseen_nxt = step_mseen; cnt_nxt = step_cnt;
    tot_res = nres; f_len0 = len0; f_len1 = len1; f_cls0 = cls0; f_cls1 = cls1;
    if (in_chunk_end) begin
      if (step_mode != M_IDLE && step_cnt != '0) begin
        if (nres == 2'd0) begin
          tot_res = 2'd1; f_len0 = 16'(step_cnt); f_cls0 = tail_cls;
        end else begin
          tot_res = 2'd2; f_len1 = 16'(step_cnt); f_cls1 = tail_cls;
        end
      end
      mode_nxt = M_IDLE; col0_nxt = 1'b1; mseen_nxt = 1'b0; cnt_nxt = '0;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (pend_r != 2'd0 && !out_stall) pend_nxt = pend_r - 2'd1;
    if (accept) pend_nxt = tot_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; col0_r <= 1'b1; mseen_r <= 1'b0; cnt_r <= '0;
      wlen_r <= '0; dot_r <= '0; quote_r <= '0; pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (accept) begin
        mode_r <= mode_nxt; col0_r <= col0_nxt; mseen_r <= mseen_nxt; cnt_r <= cnt_nxt;
        wlen_r <= wlen_nxt; dot_r <= dot_nxt; quote_r <= quote_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wbuf_r <= wbuf_nxt;
      len0_r <= f_len0; cls0_r <= f_cls0; len1_r <= f_len1; cls1_r <= f_cls1;
    end else if (pend_r == 2'd2 && !out_stall) begin
      len0_r <= len1_r; cls0_r <= cls1_r;
    end
  end

  assign out_valid = pend_r != 2'd0;
  assign out_run_length = len0_r;
  assign out_style_class = cls0_r;
  assign out_run_last = pend_r == 2'd1;
endmodule
`default_nettype wire

// ----- rtl/astc_word_class.sv -----
// Word classifier: size-suffix strip and keyword match on the word buffer.
`default_nettype none
module astc_word_class import astc_pkg::*; #(
  parameter int MAX_WORD = 10
) (
  input  wire logic [MAX_WORD*8-1:0]         word_chars,
  input  wire logic [$clog2(MAX_WORD+2)-1:0] word_len,
  input  wire logic [$clog2(MAX_WORD+2)-1:0] last_dot_pos,
  input  wire logic                          operand,
  output style_t                             word_style
);
  localparam int LW = $clog2(MAX_WORD + 2);

  logic [LW-1:0] eff_len;
  logic [7:0]    sfx;
  kw_t           word_kw;
  logic          sfx_ok;

  always_comb begin
    sfx = 8'd0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (LW'(i + 1) == word_len) sfx = lower(word_chars[i*8 +: 8]);
    end
    sfx_ok = (sfx == 8'h62 || sfx == 8'h77 || sfx == 8'h6C || sfx == 8'h73);
    eff_len = word_len;
    if (!operand && last_dot_pos > LW'(1) && last_dot_pos + LW'(1) == word_len && sfx_ok)
      eff_len = last_dot_pos - LW'(1);
    word_kw = '0;
    for (int i = 0; i < KW_LEN && i < MAX_WORD; i++) begin
      if (LW'(i) < eff_len) word_kw[i*8 +: 8] = lower(word_chars[i*8 +: 8]);
    end
    word_style = C_DEFAULT;
    if (word_len <= LW'(MAX_WORD) && eff_len <= LW'(KW_LEN)) begin
      if (operand) begin
        if (is_reg(word_kw)) word_style = C_REGISTER;
      end else if (is_mnem(word_kw)) begin
        word_style = C_MNEMONIC;
      end else if (is_dir(word_kw)) begin
        word_style = C_DIRECTIVE;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/astc_step.sv -----
// Step logic: next scan state and the runs one character produces before chunk-end handling.
`default_nettype none
module astc_step import astc_pkg::*; #(
  parameter int RUN_MAX = 65535
) (
  input  wire logic [7:0]                   c,
  input  wire scan_mode_t                   mode,
  input  wire logic                         col0,
  input  wire logic                         mseen,
  input  wire logic [$clog2(RUN_MAX+1)-1:0] cnt,
  input  wire logic [7:0]                   quote,
  input  wire style_t                       oclass,
  output scan_mode_t                        mode_o,
  output logic [$clog2(RUN_MAX+1)-1:0]      cnt_o,
  output logic                              col0_o,
  output logic                              mseen_o,
  output logic [7:0]                        quote_o,
  output logic                              push_o,
  output logic                              start_o,
  output logic [1:0]                        nres_o,
  output logic [15:0]                       len0_o,
  output logic [15:0]                       len1_o,
  output style_t                            cls0_o,
  output style_t                            cls1_o
);
  localparam int RW = $clog2(RUN_MAX + 1);
  logic used, flush, grow;
  logic [RW:0] cg;
  always_comb begin
    mode_o = mode; cnt_o = cnt; col0_o = col0; mseen_o = mseen; quote_o = quote;
    push_o = 1'b0; start_o = 1'b0;
    nres_o = 2'd0; len0_o = '0; len1_o = '0; cls0_o = C_DEFAULT; cls1_o = C_DEFAULT;
    used = 1'b0; flush = 1'b0; grow = 1'b0; cg = '0;
    unique case (mode)
      M_COMMENT: if (c == CH_NL) flush = 1'b1; else begin grow = 1'b1; used = 1'b1; end
      M_STRING:
        if (c == quote) begin cnt_o = cnt + RW'(1); flush = 1'b1; used = 1'b1; end
        else if (c == CH_NL) flush = 1'b1;
        else begin
          if (c == CH_BSLASH) mode_o = M_ESCAPE;
          grow = 1'b1; used = 1'b1;
        end
      M_ESCAPE: begin mode_o = M_STRING; grow = 1'b1; used = 1'b1; end
      M_NUMBER:
        if (is_letter(c) || is_number(c)) begin grow = 1'b1; used = 1'b1; end
        else flush = 1'b1;
      M_LABEL, M_OPCODE, M_OPERAND:
        if (is_ident(c)) begin push_o = 1'b1; grow = 1'b1; used = 1'b1; end
        else if (mode == M_LABEL && c == CH_COLON) begin
          cnt_o = cnt + RW'(1); flush = 1'b1; used = 1'b1;
        end else flush = 1'b1;
      default: ;
    endcase
    if (grow) begin
      cg = {1'b0, cnt} + (RW+1)'(1);
      if (cg >= (RW+1)'(RUN_MAX)) begin
        nres_o = 2'd1; len0_o = 16'(cg); cls0_o = oclass; cnt_o = '0;
      end else cnt_o = cg[RW-1:0];
    end
    if (flush) begin
      if (cnt_o != '0) begin nres_o = 2'd1; len0_o = 16'(cnt_o); cls0_o = oclass; end
      if (mode == M_OPCODE) mseen_o = 1'b1;
      cnt_o = '0; mode_o = M_IDLE;
    end
    if (!used) begin
      if (c == CH_NL) begin
        if (nres_o == 2'd0) begin nres_o = 2'd1; len0_o = 16'd1; cls0_o = C_DEFAULT; end
        else begin nres_o = 2'd2; len1_o = 16'd1; cls1_o = C_DEFAULT; end
        col0_o = 1'b1; mseen_o = 1'b0;
      end else begin
        if (c == CH_SEMI || (c == CH_STAR && col0)) begin
          mode_o = M_COMMENT; cnt_o = RW'(1);
        end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          mode_o = M_STRING; quote_o = c; cnt_o = RW'(1);
        end else if (c == CH_DOLLAR || c == CH_PCT || (c >= 8'h30 && c <= 8'h39)) begin
          mode_o = M_NUMBER; cnt_o = RW'(1);
        end else if (is_letter(c) || c == CH_UNDER || c == CH_DOT || c == CH_AT) begin
          start_o = 1'b1;
          cnt_o = RW'(1);
          if (col0 && !mseen_o) mode_o = M_LABEL;
          else if (!mseen_o) mode_o = M_OPCODE;
          else mode_o = M_OPERAND;
        end else begin
          if (nres_o == 2'd0) begin nres_o = 2'd1; len0_o = 16'd1; cls0_o = C_DEFAULT; end
          else begin nres_o = 2'd2; len1_o = 16'd1; cls1_o = C_DEFAULT; end
        end
        col0_o = 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/astc_checker.sv -----
// Port checker for the token classifier, bound to the top level.
`default_nettype none
module astc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_run_length,
  input wire logic        out_run_last
);
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != 16'd0) else $error("zero-length run");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_run_length))
    else $error("stalled run changed");
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no pending run");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("run offered after reset");
  a_not_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last && !out_stall |=> out_valid)
    else $error("run chain broken");
endmodule

bind asm_source_token_classifier astc_checker u_astc_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_run_length(out_run_length), .out_run_last(out_run_last)
);
`default_nettype wire
